>>> hw/rtl/les_pkg.sv
package les_pkg;

    localparam int MAX_LEDS  = 64;
    localparam int MAX_GROUP = 16;

    localparam int LED_W     = $clog2(MAX_LEDS);
    localparam int GRP_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam int CNT_W     = $clog2(MAX_LEDS + 1);
    localparam int GCNT_W    = $clog2(MAX_GROUP + 1);
    localparam int POS_W     = 8;
    localparam int POS_EXT_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

    localparam int COLOR_W   = 24;
    localparam int CH_W      = 8;
    localparam int NCH       = 3;
    localparam logic [CH_W-1:0] CH_TOP = 8'hFF;

    localparam int KIND_W    = 3;
    localparam int GCFG_W    = 5;
    localparam int LCFG_W    = 7;
    localparam int IDX_W     = 6;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE   = 2'd0,
        MODE_READ    = 2'd1,
        MODE_ADVANCE = 2'd2,
        MODE_RESTART = 2'd3
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 3'd0,
        KIND_ONCE    = 3'd1,
        KIND_BREATH  = 3'd2,
        KIND_MARQUEE = 3'd3,
        KIND_WATER   = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EFFECT_KIND  = 3'd0,
        REG_GROUP_COUNT  = 3'd1,
        REG_BASE_COLOR   = 3'd2,
        REG_LED_COUNT    = 3'd3,
        REG_BREATH_STEP  = 3'd4,
        REG_BREATH_FLOOR = 3'd5
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_BR_LOAD,
        ST_FILL,
        ST_MQ_SAVE_RD,
        ST_MQ_SAVE_WR,
        ST_MQ_SHIFT_RD,
        ST_MQ_SHIFT_WR,
        ST_MQ_REST_RD,
        ST_MQ_REST_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [CNT_W-1:0]   n;
        logic [GCNT_W-1:0]  g;
        logic [COLOR_W-1:0] base;
        logic [CH_W-1:0]    step;
        logic [CH_W-1:0]    floor_lvl;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [COLOR_W-1:0] color;
        logic               down;
    } res_t;

endpackage

>>> hw/rtl/les_ram.sv
module les_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/les_seq.sv
module les_seq (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [les_pkg::MODE_W-1:0]   in_mode,
    input  logic [les_pkg::IDX_W-1:0]    in_idx,
    input  logic [les_pkg::COLOR_W-1:0]  in_color,
    input  les_pkg::cfg_t                cfg,
    input  logic                         out_free,
    output logic                         idle,
    output les_pkg::res_t                res
);

    localparam int PW = les_pkg::POS_EXT_W;
    localparam int CW = les_pkg::CNT_W;

    les_pkg::state_t state_reg, state_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic signed [PW-1:0]          start_reg, start_next;
    logic [CW-1:0]                 len_reg, len_next;
    logic [les_pkg::COLOR_W-1:0]   fill_reg, fill_next;
    logic [les_pkg::COLOR_W-1:0]   rd_reg, rd_next;
    logic                          dir_reg, dir_next;
    logic [les_pkg::POS_W-1:0]     pos_reg, pos_next;

    logic                          px_we;
    logic [les_pkg::LED_W-1:0]     px_waddr, px_raddr;
    logic [les_pkg::COLOR_W-1:0]   px_wdata, px_rdata;
    logic                          sv_we;
    logic [les_pkg::GRP_W-1:0]     sv_waddr, sv_raddr;
    logic [les_pkg::COLOR_W-1:0]   sv_wdata, sv_rdata;

    les_ram #(.WIDTH(les_pkg::COLOR_W), .DEPTH(les_pkg::MAX_LEDS)) u_pixel_ram (
        .aclk  (aclk),
        .we    (px_we),
        .waddr (px_waddr),
        .wdata (px_wdata),
        .raddr (px_raddr),
        .rdata (px_rdata)
    );

    les_ram #(.WIDTH(les_pkg::COLOR_W), .DEPTH(les_pkg::MAX_GROUP)) u_save_ram (
        .aclk  (aclk),
        .we    (sv_we),
        .waddr (sv_waddr),
        .wdata (sv_wdata),
        .raddr (sv_raddr),
        .rdata (sv_rdata)
    );

    // water step decision
    logic signed [PW-1:0] w_p0, w_n, w_g, w_p;
    logic                 w_dir;
    logic signed [PW-1:0] w_pos;

    always_comb begin
        w_p0 = {{(PW-les_pkg::POS_W){pos_reg[les_pkg::POS_W-1]}}, pos_reg};
        w_n  = $signed(PW'(cfg.n));
        w_g  = $signed(PW'(cfg.g));
        w_dir = dir_reg;
        w_p   = w_p0;
        if (!dir_reg && (w_n < w_p0 + w_g)) begin
            w_dir = 1'b1;
            w_p   = w_p0 - w_g;
        end else if (dir_reg && (w_p0 < 0)) begin
            w_dir = 1'b0;
            w_p   = '0;
        end
        w_pos = w_dir ? (w_p - w_g) : (w_p + w_g);
    end

    // breath step from LED0
    logic [les_pkg::CH_W-1:0]    br_r, br_s, br_v, br_head, br_diff;
    logic                        br_zero, br_dir;
    logic [les_pkg::COLOR_W-1:0] br_color;

    always_comb begin
        br_r    = cfg.step;
        br_zero = 1'b0;
        for (int k = 0; k < les_pkg::NCH; k++) begin
            br_v    = px_rdata[les_pkg::COLOR_W-les_pkg::CH_W*(k+1) +: les_pkg::CH_W];
            br_head = les_pkg::CH_TOP - br_v;
            br_diff = br_v - cfg.floor_lvl;
            if (!dir_reg) begin
                if (br_head == '0) begin
                    br_zero = 1'b1;
                end else if (br_head < br_r) begin
                    br_r = br_head;
                end
            end else begin
                if (br_v == cfg.floor_lvl) begin
                    br_zero = 1'b1;
                end else if (br_v > cfg.floor_lvl && br_diff < br_r) begin
                    br_r = br_diff;
                end
            end
        end
        // a zero step also reverses
        br_dir = (br_zero || br_r == '0) ? ~dir_reg : dir_reg;
        br_s   = (br_zero || br_r == '0) ? cfg.step : br_r;
        for (int k = 0; k < les_pkg::NCH; k++) begin
            br_v = px_rdata[les_pkg::COLOR_W-les_pkg::CH_W*(k+1) +: les_pkg::CH_W];
            if (br_v != '0) begin
                br_v = br_dir ? (br_v - br_s) : (br_v + br_s);
            end
            br_color[les_pkg::COLOR_W-les_pkg::CH_W*(k+1) +: les_pkg::CH_W] = br_v;
        end
    end

    logic [CW-1:0]        keep;
    logic [CW-1:0]        g_cnt;
    logic signed [PW-1:0] fill_addr;

    assign g_cnt     = CW'(cfg.g);
    assign keep      = cfg.n - g_cnt;
    assign fill_addr = start_reg + $signed(PW'(cnt_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= les_pkg::ST_IDLE;
            dir_reg   <= 1'b0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            dir_reg   <= dir_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        start_reg <= start_next;
        len_reg   <= len_next;
        fill_reg  <= fill_next;
        rd_reg    <= rd_next;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        start_next = start_reg;
        len_next   = len_reg;
        fill_next  = fill_reg;
        rd_next    = rd_reg;
        dir_next   = dir_reg;
        pos_next   = pos_reg;
        px_we      = 1'b0;
        px_waddr   = les_pkg::LED_W'(cnt_reg);
        px_wdata   = sv_rdata;
        px_raddr   = les_pkg::LED_W'(cnt_reg);
        sv_we      = 1'b0;
        sv_waddr   = les_pkg::GRP_W'(cnt_reg);
        sv_wdata   = px_rdata;
        sv_raddr   = les_pkg::GRP_W'(cnt_reg);

        unique case (state_reg)
            les_pkg::ST_IDLE: begin
                if (start) begin
                    rd_next    = '0;
                    cnt_next   = '0;
                    start_next = '0;
                    state_next = les_pkg::ST_DONE;
                    unique case (les_pkg::mode_t'(in_mode))
                        les_pkg::MODE_WRITE: begin
                            if (int'(in_idx) < les_pkg::MAX_LEDS) begin
                                px_we    = 1'b1;
                                px_waddr = les_pkg::LED_W'(in_idx);
                                px_wdata = in_color;
                            end
                        end
                        les_pkg::MODE_READ: begin
                            px_raddr = les_pkg::LED_W'(in_idx);
                            if (int'(in_idx) < les_pkg::MAX_LEDS) begin
                                state_next = les_pkg::ST_READ;
                            end
                        end
                        les_pkg::MODE_ADVANCE: begin
                            case (cfg.kind)
                                les_pkg::KIND_BREATH: begin
                                    px_raddr   = '0;
                                    state_next = les_pkg::ST_BR_LOAD;
                                end
                                les_pkg::KIND_MARQUEE: begin
                                    state_next = les_pkg::ST_MQ_SAVE_RD;
                                end
                                les_pkg::KIND_WATER: begin
                                    dir_next   = w_dir;
                                    pos_next   = w_pos[les_pkg::POS_W-1:0];
                                    start_next = w_p;
                                    len_next   = g_cnt;
                                    fill_next  = w_dir ? '0 : cfg.base;
                                    state_next = les_pkg::ST_FILL;
                                end
                                default: ;
                            endcase
                        end
                        les_pkg::MODE_RESTART: begin
                            case (cfg.kind)
                                les_pkg::KIND_BREATH: begin
                                    dir_next   = 1'b0;
                                    len_next   = cfg.n;
                                    fill_next  = cfg.base;
                                    state_next = les_pkg::ST_FILL;
                                end
                                les_pkg::KIND_WATER: begin
                                    dir_next   = 1'b0;
                                    pos_next   = les_pkg::POS_W'(cfg.g);
                                    len_next   = g_cnt;
                                    fill_next  = cfg.base;
                                    state_next = les_pkg::ST_FILL;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            les_pkg::ST_READ: begin
                rd_next    = px_rdata;
                state_next = les_pkg::ST_DONE;
            end
            les_pkg::ST_BR_LOAD: begin
                dir_next   = br_dir;
                fill_next  = br_color;
                len_next   = cfg.n;
                state_next = les_pkg::ST_FILL;
            end
            les_pkg::ST_FILL: begin
                if (!fill_addr[PW-1] && (fill_addr < $signed(PW'(cfg.n)))) begin
                    px_we    = 1'b1;
                    px_waddr = les_pkg::LED_W'(fill_addr);
                    px_wdata = fill_reg;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg + 1'b1 == len_reg) begin
                    state_next = les_pkg::ST_DONE;
                end
            end
            les_pkg::ST_MQ_SAVE_RD: begin
                px_raddr   = les_pkg::LED_W'(keep + cnt_reg);
                state_next = les_pkg::ST_MQ_SAVE_WR;
            end
            les_pkg::ST_MQ_SAVE_WR: begin
                sv_we = 1'b1;
                if (cnt_reg == g_cnt - 1'b1) begin
                    if (keep == '0) begin
                        cnt_next   = '0;
                        state_next = les_pkg::ST_MQ_REST_RD;
                    end else begin
                        cnt_next   = keep - 1'b1;
                        state_next = les_pkg::ST_MQ_SHIFT_RD;
                    end
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = les_pkg::ST_MQ_SAVE_RD;
                end
            end
            les_pkg::ST_MQ_SHIFT_RD: begin
                state_next = les_pkg::ST_MQ_SHIFT_WR;
            end
            les_pkg::ST_MQ_SHIFT_WR: begin
                px_we    = 1'b1;
                px_waddr = les_pkg::LED_W'(cnt_reg + g_cnt);
                px_wdata = px_rdata;
                if (cnt_reg == '0) begin
                    state_next = les_pkg::ST_MQ_REST_RD;
                end else begin
                    cnt_next   = cnt_reg - 1'b1;
                    state_next = les_pkg::ST_MQ_SHIFT_RD;
                end
            end
            les_pkg::ST_MQ_REST_RD: begin
                state_next = les_pkg::ST_MQ_REST_WR;
            end
            les_pkg::ST_MQ_REST_WR: begin
                px_we = 1'b1;
                if (cnt_reg == g_cnt - 1'b1) begin
                    state_next = les_pkg::ST_DONE;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = les_pkg::ST_MQ_REST_RD;
                end
            end
            les_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = les_pkg::ST_IDLE;
                end
            end
            default: state_next = les_pkg::ST_IDLE;
        endcase
    end

    assign idle      = (state_reg == les_pkg::ST_IDLE);
    assign res.valid = (state_reg == les_pkg::ST_DONE);
    assign res.color = rd_reg;
    assign res.down  = dir_reg;

endmodule

>>> hw/rtl/led_strip_effect_engine_unit.sv
// Items run through a sequencer: a pixel write or a no-op goes straight to done,
// a read passes the read state, breath and water fill the frame store, and a
// marquee advance saves the last g of n pixels, shifts the rest up, restores at the front.
// One item in work at a time; a new item is taken only once the pixel memory walk is done.
// A finished result waits in the output register while the next item is taken.
// Synchronous active-low reset clears control state, direction and position and loads
// the register defaults; the frame store holds nothing defined until written.
module led_strip_effect_engine_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // led_index[5:0], color_in[29:6]
    input  logic [les_pkg::MODE_W-1:0]      s_tuser,   // mode[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // color_out[23:0], going_down[24]
    input  logic                            cfg_wr_en,
    input  logic [les_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [les_pkg::COLOR_W-1:0]     cfg_data
);

    logic [les_pkg::KIND_W-1:0]  effect_kind_reg;
    logic [les_pkg::GCFG_W-1:0]  group_count_reg;
    logic [les_pkg::COLOR_W-1:0] base_color_reg;
    logic [les_pkg::LCFG_W-1:0]  led_count_reg;
    logic [les_pkg::CH_W-1:0]    breath_step_reg;
    logic [les_pkg::CH_W-1:0]    breath_floor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            effect_kind_reg  <= les_pkg::KIND_NONE;
            group_count_reg  <= les_pkg::GCFG_W'(1);
            base_color_reg   <= '0;
            led_count_reg    <= les_pkg::LCFG_W'(64);
            breath_step_reg  <= les_pkg::CH_W'(5);
            breath_floor_reg <= les_pkg::CH_W'(10);
        end else if (cfg_wr_en) begin
            unique case (les_pkg::reg_idx_t'(cfg_index))
                les_pkg::REG_EFFECT_KIND:  effect_kind_reg  <= cfg_data[les_pkg::KIND_W-1:0];
                les_pkg::REG_GROUP_COUNT:  group_count_reg  <= cfg_data[les_pkg::GCFG_W-1:0];
                les_pkg::REG_BASE_COLOR:   base_color_reg   <= cfg_data;
                les_pkg::REG_LED_COUNT:    led_count_reg    <= cfg_data[les_pkg::LCFG_W-1:0];
                les_pkg::REG_BREATH_STEP:  breath_step_reg  <= cfg_data[les_pkg::CH_W-1:0];
                les_pkg::REG_BREATH_FLOOR: breath_floor_reg <= cfg_data[les_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp LED count and group size
    les_pkg::cfg_t cfg;

    always_comb begin
        cfg.kind      = effect_kind_reg;
        cfg.base      = base_color_reg;
        cfg.step      = breath_step_reg;
        cfg.floor_lvl = breath_floor_reg;
        if (led_count_reg == '0) begin
            cfg.n = les_pkg::CNT_W'(1);
        end else if (int'(led_count_reg) > les_pkg::MAX_LEDS) begin
            cfg.n = les_pkg::CNT_W'(les_pkg::MAX_LEDS);
        end else begin
            cfg.n = les_pkg::CNT_W'(led_count_reg);
        end
        if (group_count_reg == '0) begin
            cfg.g = les_pkg::GCNT_W'(1);
        end else if (int'(group_count_reg) > les_pkg::MAX_GROUP) begin
            cfg.g = les_pkg::GCNT_W'(les_pkg::MAX_GROUP);
        end else begin
            cfg.g = les_pkg::GCNT_W'(group_count_reg);
        end
        if (int'(cfg.g) > int'(cfg.n)) begin
            cfg.g = les_pkg::GCNT_W'(cfg.n);
        end
    end

    logic          seq_idle;
    logic          out_free;
    les_pkg::res_t res;

    logic                        m_tvalid_reg;
    logic [les_pkg::COLOR_W-1:0] color_out_reg;
    logic                        going_down_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = seq_idle;

    les_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_tvalid && s_tready),
        .in_mode  (s_tuser),
        .in_idx   (s_tdata[les_pkg::IDX_W-1:0]),
        .in_color (s_tdata[les_pkg::IDX_W +: les_pkg::COLOR_W]),
        .cfg      (cfg),
        .out_free (out_free),
        .idle     (seq_idle),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res.valid) begin
            color_out_reg  <= res.color;
            going_down_reg <= res.down;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, going_down_reg, color_out_reg};

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import les_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               down;
    } strip_reply_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } rx_style_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;
    logic [MODE_W-1:0]    s_tuser   = MODE_WRITE;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_EFFECT_KIND;
    logic [COLOR_W-1:0]   cfg_data  = '0;

    // predicted strip state and register copy
    logic [COLOR_W-1:0] frame [MAX_LEDS];
    logic [COLOR_W-1:0] spill [MAX_GROUP];
    logic               dir_down  = 1'b0;
    logic [7:0]         water_pos = 8'd0;
    logic [KIND_W-1:0]  k_kind    = KIND_NONE;
    logic [GCFG_W-1:0]  k_group   = 5'd1;
    logic [COLOR_W-1:0] k_base    = '0;
    logic [LCFG_W-1:0]  k_leds    = 7'd64;
    logic [CH_W-1:0]    k_step    = 8'd5;
    logic [CH_W-1:0]    k_floor   = 8'd10;

    strip_reply_t strip_replies[$];
    int           mismatch_count = 0;
    int           burst_left     = 0;
    int           quiet_cycles   = 0;
    int           rx_cycle       = 0;
    int           rx_hold        = 0;
    rx_style_t    rx_style       = RX_OPEN;

    led_strip_effect_engine_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic void flag_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endfunction

    function automatic void fill_span(input int start, input int len, input int n,
                                      input logic [COLOR_W-1:0] c);
        int idx;
        for (int i = 0; i < len; i++) begin
            idx = start + i;
            if (idx >= 0 && idx < n) frame[idx] = c;
        end
    endfunction

    function automatic logic [COLOR_W-1:0] with_noise(input logic [COLOR_W-1:0] v,
                                                      input int width);
        logic [COLOR_W-1:0] junk;
        junk = COLOR_W'($urandom);
        junk = junk & ~((24'd1 << width) - 24'd1);
        if ($urandom_range(0, 3) == 0) return v | junk;
        return v;
    endfunction

    task automatic predict_strip_item(input mode_t m, input logic [IDX_W-1:0] idx,
                                      input logic [COLOR_W-1:0] cin);
        strip_reply_t       r;
        int                 n;
        int                 g;
        int                 p;
        int                 keep;
        logic [COLOR_W-1:0] c;
        logic [COLOR_W-1:0] lit;
        logic [CH_W-1:0]    v;
        logic [CH_W-1:0]    s;
        logic               stop;
        n = int'(k_leds);
        if (n < 1) n = 1;
        if (n > MAX_LEDS) n = MAX_LEDS;
        g = int'(k_group);
        if (g < 1) g = 1;
        if (g > MAX_GROUP) g = MAX_GROUP;
        if (g > n) g = n;
        r.color = '0;
        case (m)
            MODE_WRITE: begin
                frame[idx] = cin;
            end
            MODE_READ: begin
                r.color = frame[idx];
            end
            MODE_ADVANCE: begin
                if (k_kind == KIND_BREATH) begin
                    c    = frame[0];
                    s    = k_step;
                    stop = 1'b0;
                    for (int k = 0; k < NCH; k++) begin
                        if (!stop) begin
                            v = c[(2 - k) * 8 +: 8];
                            if (!dir_down) begin
                                if (v == CH_TOP) begin
                                    s = 8'd0;
                                    stop = 1'b1;
                                end else if (CH_TOP - v < s) begin
                                    s = CH_TOP - v;
                                end
                            end else begin
                                if (v == k_floor) begin
                                    s = 8'd0;
                                    stop = 1'b1;
                                end else if (v > k_floor && v - k_floor < s) begin
                                    s = v - k_floor;
                                end
                            end
                        end
                    end
                    if (s == 8'd0) begin
                        dir_down = ~dir_down;
                        s = k_step;
                    end
                    lit = '0;
                    for (int k = 0; k < NCH; k++) begin
                        v = c[(2 - k) * 8 +: 8];
                        if (v != 8'd0) v = dir_down ? v - s : v + s;
                        lit[(2 - k) * 8 +: 8] = v;
                    end
                    for (int i = 0; i < n; i++) frame[i] = lit;
                end else if (k_kind == KIND_MARQUEE) begin
                    keep = n - g;
                    for (int i = 0; i < g; i++) spill[i] = frame[keep + i];
                    for (int i = keep - 1; i >= 0; i--) frame[i + g] = frame[i];
                    for (int i = 0; i < g; i++) frame[i] = spill[i];
                end else if (k_kind == KIND_WATER) begin
                    p = int'($signed(water_pos));
                    if (!dir_down) begin
                        if (n < p + g) begin
                            dir_down = 1'b1;
                            p -= g;
                        end
                    end else if (p < 0) begin
                        dir_down = 1'b0;
                        p = 0;
                    end
                    if (!dir_down) begin
                        fill_span(p, g, n, k_base);
                        p += g;
                    end else begin
                        fill_span(p, g, n, '0);
                        p -= g;
                    end
                    water_pos = p[7:0];
                end
            end
            default: begin
                if (k_kind == KIND_BREATH) begin
                    fill_span(0, n, n, k_base);
                    dir_down = 1'b0;
                end else if (k_kind == KIND_WATER) begin
                    fill_span(0, g, n, k_base);
                    dir_down = 1'b0;
                    water_pos = g[7:0];
                end
            end
        endcase
        r.down = dir_down;
        strip_replies.push_back(r);
    endtask

    task automatic send_item(input mode_t m, input logic [IDX_W-1:0] idx,
                             input logic [COLOR_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {2'b00, c, idx};
        do @(posedge aclk); while (!s_tready);
        predict_strip_item(m, idx, c);
    endtask

    task automatic write_reg(input reg_idx_t r, input logic [COLOR_W-1:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge aclk);
        case (r)
            REG_EFFECT_KIND:  k_kind  = v[KIND_W-1:0];
            REG_GROUP_COUNT:  k_group = v[GCFG_W-1:0];
            REG_BASE_COLOR:   k_base  = v;
            REG_LED_COUNT:    k_leds  = v[LCFG_W-1:0];
            REG_BREATH_STEP:  k_step  = v[CH_W-1:0];
            REG_BREATH_FLOOR: k_floor = v[CH_W-1:0];
            default: ;
        endcase
    endtask

    // registers change only with the block idle
    task automatic reconfigure(input logic [COLOR_W-1:0] kind_v, input logic [COLOR_W-1:0] grp_v,
                               input logic [COLOR_W-1:0] base_v, input logic [COLOR_W-1:0] leds_v,
                               input logic [COLOR_W-1:0] step_v, input logic [COLOR_W-1:0] lvl_v);
        s_tvalid <= 1'b0;
        while (strip_replies.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        write_reg(REG_EFFECT_KIND, kind_v);
        write_reg(REG_GROUP_COUNT, grp_v);
        write_reg(REG_BASE_COLOR, base_v);
        write_reg(REG_LED_COUNT, leds_v);
        write_reg(REG_BREATH_STEP, step_v);
        write_reg(REG_BREATH_FLOOR, lvl_v);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_fill_store();
        logic [COLOR_W-1:0] c;
        for (int i = 0; i < MAX_LEDS; i++) begin
            c = COLOR_W'($urandom);
            if (i == 0) c = 24'hFFFFFF;
            if (i == MAX_LEDS - 1) c = 24'h000000;
            send_item(MODE_WRITE, i[IDX_W-1:0], c);
        end
    endtask

    task automatic test_pixel_access();
        send_item(MODE_READ, 6'd0, 24'hFFFFFF);
        send_item(MODE_READ, 6'd63, 24'h000000);
        send_item(MODE_WRITE, 6'd21, 24'hA5C3FF);
        send_item(MODE_READ, 6'd21, 24'h000000);
        send_item(MODE_ADVANCE, 6'd63, 24'hFFFFFF);
        send_item(MODE_RESTART, 6'd0, 24'h000000);
        reconfigure(COLOR_W'(KIND_ONCE), 24'd1, 24'h000000, 24'd64, 24'd5, 24'd10);
        send_item(MODE_ADVANCE, 6'd0, 24'h000000);
        send_item(MODE_RESTART, 6'd0, 24'h000000);
        send_item(MODE_READ, 6'd0, 24'h000000);
    endtask

    task automatic test_breath_turns();
        reconfigure(COLOR_W'(KIND_BREATH), 24'd1, 24'hFA0005, 24'd8, 24'd5, 24'd10);
        send_item(MODE_RESTART, 6'd0, 24'h000000);
        repeat (4) send_item(MODE_ADVANCE, 6'd0, 24'h000000);
        send_item(MODE_READ, 6'd7, 24'h000000);
        reconfigure(COLOR_W'(KIND_BREATH), 24'd1, 24'hFFFFFF, 24'd64, 24'd255, 24'd254);
        send_item(MODE_RESTART, 6'd0, 24'h000000);
        repeat (2) send_item(MODE_ADVANCE, 6'd0, 24'h000000);
        send_item(MODE_READ, 6'd63, 24'h000000);
    endtask

    task automatic test_marquee_rotation();
        reconfigure(COLOR_W'(KIND_MARQUEE), 24'd2, 24'h000000, 24'd5, 24'd5, 24'd10);
        repeat (2) send_item(MODE_ADVANCE, 6'd0, 24'h000000);
        send_item(MODE_READ, 6'd0, 24'h000000);
        send_item(MODE_READ, 6'd4, 24'h000000);
        reconfigure(COLOR_W'(KIND_MARQUEE), 24'd16, 24'h000000, 24'd64, 24'd5, 24'd10);
        send_item(MODE_ADVANCE, 6'd0, 24'h000000);
        send_item(MODE_READ, 6'd0, 24'h000000);
    endtask

    task automatic test_water_sweep();
        reconfigure(COLOR_W'(KIND_WATER), 24'd4, 24'h123456, 24'd10, 24'd5, 24'd10);
        send_item(MODE_RESTART, 6'd0, 24'h000000);
        repeat (6) send_item(MODE_ADVANCE, 6'd0, 24'h000000);
        send_item(MODE_READ, 6'd9, 24'h000000);
        send_item(MODE_READ, 6'd0, 24'h000000);
    endtask

    task automatic test_register_limits();
        reconfigure(COLOR_W'(KIND_MARQUEE), 24'hFFFFE0, 24'h000000, 24'h000080, 24'd5, 24'd10);
        send_item(MODE_ADVANCE, 6'd0, 24'h000000);
        send_item(MODE_READ, 6'd0, 24'h000000);
        reconfigure(24'hFFFFFF, 24'd31, 24'hFFFFFF, 24'd127, 24'hFFFFFF, 24'hFFFFFF);
        send_item(MODE_ADVANCE, 6'd0, 24'h000000);
        send_item(MODE_RESTART, 6'd0, 24'h000000);
        reconfigure(COLOR_W'(KIND_BREATH), 24'd1, 24'h01FF00, 24'd3, 24'd0, 24'd255);
        send_item(MODE_RESTART, 6'd0, 24'h000000);
        repeat (2) send_item(MODE_ADVANCE, 6'd0, 24'h000000);
        send_item(MODE_READ, 6'd2, 24'h000000);
    endtask

    task automatic test_random_traffic();
        int                 left;
        int                 phase_len;
        int                 pick;
        logic [COLOR_W-1:0] kind_v;
        logic [COLOR_W-1:0] grp_v;
        logic [COLOR_W-1:0] base_v;
        logic [COLOR_W-1:0] leds_v;
        logic [COLOR_W-1:0] step_v;
        logic [COLOR_W-1:0] lvl_v;
        logic [COLOR_W-1:0] c;
        logic [IDX_W-1:0]   idx;
        left = 800;
        while (left > 0) begin
            kind_v = COLOR_W'(($urandom_range(0, 9) < 2) ? $urandom_range(0, 7)
                                                         : $urandom_range(2, 4));
            grp_v  = COLOR_W'(($urandom_range(0, 9) < 3) ? $urandom_range(0, 31)
                                                         : $urandom_range(1, 16));
            pick   = $urandom_range(0, 9);
            if (pick < 2) leds_v = COLOR_W'($urandom_range(0, 127));
            else if (pick < 6) leds_v = COLOR_W'($urandom_range(1, 16));
            else leds_v = COLOR_W'($urandom_range(1, 64));
            base_v = COLOR_W'($urandom);
            pick   = $urandom_range(0, 7);
            if (pick == 0) base_v = 24'hFFFFFF;
            else if (pick == 1) base_v = 24'h000000;
            step_v = COLOR_W'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 16)
                                                          : $urandom_range(0, 255));
            lvl_v  = COLOR_W'($urandom_range(0, 255));
            reconfigure(with_noise(kind_v, KIND_W), with_noise(grp_v, GCFG_W), base_v,
                        with_noise(leds_v, LCFG_W), with_noise(step_v, CH_W),
                        with_noise(lvl_v, CH_W));
            if (k_kind == KIND_BREATH || k_kind == KIND_WATER)
                send_item(MODE_RESTART, IDX_W'($urandom), COLOR_W'($urandom));
            phase_len = $urandom_range(40, 110);
            if (phase_len > left) phase_len = left;
            left -= phase_len;
            repeat (phase_len) begin
                pick = $urandom_range(0, 99);
                idx  = IDX_W'($urandom);
                c    = COLOR_W'($urandom);
                if (pick < 20) send_item(MODE_WRITE, idx, c);
                else if (pick < 42) send_item(MODE_READ, idx, c);
                else if (pick < 92) send_item(MODE_ADVANCE, idx, c);
                else send_item(MODE_RESTART, idx, c);
            end
        end
    endtask

    // receiver back-pressure
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 0) rx_style <= rx_style_t'($urandom_range(0, 3));
        case (rx_style)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (rx_cycle[2:0] == 3'd0);
            default: begin
                if (rx_hold != 0) begin
                    m_tready <= 1'b0;
                    rx_hold  <= rx_hold - 1;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 3) == 0) rx_hold <= $urandom_range(5, 40);
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        strip_reply_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (strip_replies.size() == 0) begin
                flag_error($sformatf("unexpected item: color %06h down %0b",
                                     m_tdata[23:0], m_tdata[24]));
            end else begin
                want = strip_replies.pop_front();
                if (m_tdata[23:0] !== want.color || m_tdata[24] !== want.down)
                    flag_error($sformatf("mismatch: color exp %06h got %06h, down exp %0b got %0b",
                                         want.color, m_tdata[23:0], want.down, m_tdata[24]));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < MAX_LEDS; i++) frame[i] = '0;
        for (int i = 0; i < MAX_GROUP; i++) spill[i] = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fill_store();
        test_pixel_access();
        test_breath_turns();
        test_marquee_rotation();
        test_water_sweep();
        test_register_limits();
        test_random_traffic();
        s_tvalid <= 1'b0;
        while (strip_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
